FILE: design/video_gate_array_palette_and_banking_defines.svh
// ----------------------------------------------------------------------------
// Video gate array assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef VIDEO_GATE_ARRAY_PALETTE_AND_BANKING_DEFINES_SVH
`define VIDEO_GATE_ARRAY_PALETTE_AND_BANKING_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define VGPB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define VGPB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/vgpb_pkg.sv
// ----------------------------------------------------------------------------
// vgpb_pkg
// Types, codes and fixed tables of the video gate array block.
// ----------------------------------------------------------------------------
package vgpb_pkg;

  localparam int unsigned PixW     = 5;
  localparam int unsigned NumPix   = 8;
  localparam int unsigned PixBusW  = PixW * NumPix;
  localparam int unsigned NumInks  = 16;

  // Port decode: bits 15:14 select the gate array
  localparam logic [1:0] GA_PORT_ID = 2'b01;

  // Pixel counts per screen mode
  localparam logic [3:0] CNT_WRITE = 4'd0;
  localparam logic [3:0] CNT_MODE0 = 4'd2;
  localparam logic [3:0] CNT_MODE1 = 4'd4;
  localparam logic [3:0] CNT_MODE2 = 4'd8;

  // Gate array commands, data bits 7:6
  typedef enum logic [1:0] {
    CMD_PEN  = 2'b00,
    CMD_INK  = 2'b01,
    CMD_MODE = 2'b10,
    CMD_RAM  = 2'b11
  } cmd_e;

  // Screen modes, mode register bits 1:0
  typedef enum logic [1:0] {
    MODE_0 = 2'd0,
    MODE_1 = 2'd1,
    MODE_2 = 2'd2,
    MODE_3 = 2'd3
  } mode_e;

  typedef logic [3:0][2:0] pages_t;

  typedef struct packed {
    logic [3:0]         pixel_count;
    logic [PixBusW-1:0] pixels;
    logic [PixW-1:0]    border_ink;
    pages_t             pages;
    logic               lower_rom_active;
    logic               upper_rom_active;
    logic [7:0]         upper_rom_number;
  } result_t;

  // Hardware colour code to palette index
  function automatic logic [PixW-1:0] colour_code(input logic [4:0] code);
    logic [PixW-1:0] c;
    case (code)
      5'd0:  c = 5'd13;  5'd1:  c = 5'd29;  5'd2:  c = 5'd19;  5'd3:  c = 5'd25;
      5'd4:  c = 5'd1;   5'd5:  c = 5'd7;   5'd6:  c = 5'd10;  5'd7:  c = 5'd16;
      5'd8:  c = 5'd28;  5'd9:  c = 5'd31;  5'd10: c = 5'd24;  5'd11: c = 5'd26;
      5'd12: c = 5'd6;   5'd13: c = 5'd8;   5'd14: c = 5'd15;  5'd15: c = 5'd17;
      5'd16: c = 5'd27;  5'd17: c = 5'd30;  5'd18: c = 5'd18;  5'd19: c = 5'd20;
      5'd20: c = 5'd0;   5'd21: c = 5'd2;   5'd22: c = 5'd9;   5'd23: c = 5'd11;
      5'd24: c = 5'd4;   5'd25: c = 5'd22;  5'd26: c = 5'd21;  5'd27: c = 5'd23;
      5'd28: c = 5'd3;   5'd29: c = 5'd5;   5'd30: c = 5'd12;  5'd31: c = 5'd14;
      default: c = 5'd0;
    endcase
    return c;
  endfunction

  // RAM configuration to page per 16K quarter; index 0 is 0000-3FFF
  function automatic pages_t page_map(input logic [2:0] cfg);
    pages_t p;
    case (cfg)
      3'd0:    p = {3'd3, 3'd2, 3'd1, 3'd0};
      3'd1:    p = {3'd7, 3'd2, 3'd1, 3'd0};
      3'd2:    p = {3'd7, 3'd6, 3'd5, 3'd4};
      3'd3:    p = {3'd7, 3'd2, 3'd3, 3'd0};
      3'd4:    p = {3'd3, 3'd2, 3'd4, 3'd0};
      3'd5:    p = {3'd3, 3'd2, 3'd5, 3'd0};
      3'd6:    p = {3'd3, 3'd2, 3'd6, 3'd0};
      3'd7:    p = {3'd3, 3'd2, 3'd7, 3'd0};
      default: p = {3'd3, 3'd2, 3'd1, 3'd0};
    endcase
    return p;
  endfunction

endpackage

FILE: design/video_gate_array_palette_and_banking.sv
// ----------------------------------------------------------------------------
// video_gate_array_palette_and_banking
// Palette, screen mode, ROM enables and RAM banking of a video gate array.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request per cycle while not stalled:
//   action_i = 0 is an I/O write of value_i to port_i, action_i = 1 decodes
//   value_i as one screen byte. Port bits 15:14 = 01 reach the gate array,
//   port bit 13 low latches the upper ROM number; both may hit one write.
//   Output channel (out_valid_o / out_stall_i) returns one result per
//   request: decoded palette indices (2, 4 or 8 by mode, none on a write)
//   and the banking and ROM state after the request.
//   Results pass through the result register, or the skid register while
//   the output stalls. Throughput: 1 request per cycle unless stalled,
//   set by the result register; all decode and state update logic sits before it.
//   A two-entry output queue (result register plus skid register) keeps
//   the input open for one more request while a result is stalled; the
//   input stalls only once the skid register holds a result.
//   Reset: palette, border, mode, banking and ROM number all clear to
//   zero (mode 0, both ROMs enabled), output queue empties.
// ----------------------------------------------------------------------------
module video_gate_array_palette_and_banking (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       action_i,
  input  logic [15:0]                port_i,
  input  logic [7:0]                 value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [3:0]                 pixel_count_o,
  output logic [vgpb_pkg::PixBusW-1:0] pixels_o,
  output logic [vgpb_pkg::PixW-1:0]  border_ink_o,
  output logic [2:0]                 page_0_o,
  output logic [2:0]                 page_1_o,
  output logic [2:0]                 page_2_o,
  output logic [2:0]                 page_3_o,
  output logic                       lower_rom_active_o,
  output logic                       upper_rom_active_o,
  output logic [7:0]                 upper_rom_number_o
);

  localparam int unsigned PixW = vgpb_pkg::PixW;

  // Architectural state
  logic [7:0]      pen_q, pen_d;
  logic [PixW-1:0] ink_q [vgpb_pkg::NumInks];
  logic [PixW-1:0] ink_d [vgpb_pkg::NumInks];
  logic [PixW-1:0] border_q, border_d;
  logic [7:0]      rom_mode_q, rom_mode_d;
  logic [2:0]      ram_cfg_q, ram_cfg_d;
  logic [7:0]      urom_q, urom_d;

  // Output queue
  vgpb_pkg::result_t out_q, skid_q, res;
  logic              out_valid_q, skid_valid_q;

  logic in_acc, out_take, wr, ga_hit, rom_hit;
  vgpb_pkg::cmd_e  cmd;
  vgpb_pkg::mode_e mode;
  logic [PixW-1:0] colour;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;

  // Port write decode
  assign wr      = in_acc && !action_i;
  assign ga_hit  = wr && (port_i[15:14] == vgpb_pkg::GA_PORT_ID);
  assign rom_hit = wr && !port_i[13];
  assign cmd     = vgpb_pkg::cmd_e'(value_i[7:6]);
  assign colour  = vgpb_pkg::colour_code(value_i[4:0]);

  // Next state
  always_comb begin
    pen_d      = pen_q;
    ink_d      = ink_q;
    border_d   = border_q;
    rom_mode_d = rom_mode_q;
    ram_cfg_d  = ram_cfg_q;
    urom_d     = rom_hit ? value_i : urom_q;
    if (ga_hit) begin
      case (cmd)
        vgpb_pkg::CMD_PEN: begin
          pen_d = value_i;
        end
        vgpb_pkg::CMD_INK: begin
          // pen bit 4 addresses the border whatever bits 3:0 hold
          if (pen_q[4]) begin
            border_d = colour;
          end else begin
            ink_d[pen_q[3:0]] = colour;
          end
        end
        vgpb_pkg::CMD_MODE: begin
          rom_mode_d = value_i;
        end
        vgpb_pkg::CMD_RAM: begin
          ram_cfg_d = value_i[2:0];
        end
        default: begin
          pen_d = pen_q;
        end
      endcase
    end
  end

  // Screen byte decode and result assembly
  assign mode = vgpb_pkg::mode_e'(rom_mode_q[1:0]);

  always_comb begin
    res                  = '0;
    res.border_ink       = border_d;
    res.pages            = vgpb_pkg::page_map(ram_cfg_d);
    res.lower_rom_active = !rom_mode_d[2];
    res.upper_rom_active = !rom_mode_d[3];
    res.upper_rom_number = urom_d;
    res.pixel_count      = vgpb_pkg::CNT_WRITE;
    if (action_i) begin
      case (mode)
        vgpb_pkg::MODE_1: begin
          res.pixel_count = vgpb_pkg::CNT_MODE1;
          for (int k = 0; k < 4; k++) begin
            res.pixels[PixW*k +: PixW] = ink_q[{2'b00, value_i[3-k], value_i[7-k]}];
          end
        end
        vgpb_pkg::MODE_2: begin
          res.pixel_count = vgpb_pkg::CNT_MODE2;
          for (int k = 0; k < 8; k++) begin
            res.pixels[PixW*k +: PixW] = value_i[7-k] ? ink_q[1] : ink_q[0];
          end
        end
        default: begin
          // mode 0, and mode 3 which decodes the same
          res.pixel_count = vgpb_pkg::CNT_MODE0;
          for (int k = 0; k < 2; k++) begin
            res.pixels[PixW*k +: PixW] =
              ink_q[{value_i[1-k], value_i[5-k], value_i[3-k], value_i[7-k]}];
          end
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q      <= '0;
      border_q   <= '0;
      rom_mode_q <= '0;
      ram_cfg_q  <= '0;
      urom_q     <= '0;
      for (int i = 0; i < vgpb_pkg::NumInks; i++) begin
        ink_q[i] <= '0;
      end
    end else begin
      pen_q      <= pen_d;
      border_q   <= border_d;
      rom_mode_q <= rom_mode_d;
      ram_cfg_q  <= ram_cfg_d;
      urom_q     <= urom_d;
      ink_q      <= ink_d;
    end
  end

  // Output queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_valid_q && !out_take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output queue payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (in_acc) begin
      if (out_valid_q && !out_take) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign pixel_count_o      = out_q.pixel_count;
  assign pixels_o           = out_q.pixels;
  assign border_ink_o       = out_q.border_ink;
  assign page_0_o           = out_q.pages[0];
  assign page_1_o           = out_q.pages[1];
  assign page_2_o           = out_q.pages[2];
  assign page_3_o           = out_q.pages[3];
  assign lower_rom_active_o = out_q.lower_rom_active;
  assign upper_rom_active_o = out_q.upper_rom_active;
  assign upper_rom_number_o = out_q.upper_rom_number;

endmodule

FILE: design/vgpb_checker.sv
// ----------------------------------------------------------------------------
// vgpb_checker
// Port-level checks of the video gate array, bound to the top level.
// ----------------------------------------------------------------------------
`include "video_gate_array_palette_and_banking_defines.svh"

module vgpb_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [3:0]                   pixel_count_o,
  input logic [vgpb_pkg::PixBusW-1:0] pixels_o,
  input logic [2:0]                   page_2_o,
  input logic [7:0]                   upper_rom_number_o
);

  // Only the mode pixel counts, or none on a write
  `VGPB_ASSERT_NOW(a_count_legal, out_valid_o,
    pixel_count_o == vgpb_pkg::CNT_WRITE || pixel_count_o == vgpb_pkg::CNT_MODE0 ||
    pixel_count_o == vgpb_pkg::CNT_MODE1 || pixel_count_o == vgpb_pkg::CNT_MODE2,
    "illegal pixel count")

  // Unused pixel slots stay zero
  `VGPB_ASSERT_NOW(a_unused_zero,
    out_valid_o && pixel_count_o != vgpb_pkg::CNT_MODE2,
    (pixel_count_o == vgpb_pkg::CNT_WRITE && pixels_o == '0) ||
    (pixel_count_o == vgpb_pkg::CNT_MODE0 && pixels_o[vgpb_pkg::PixBusW-1:10] == '0) ||
    (pixel_count_o == vgpb_pkg::CNT_MODE1 && pixels_o[vgpb_pkg::PixBusW-1:20] == '0),
    "nonzero unused pixel slot")

  // The third quarter only ever maps page 2 or page 6
  `VGPB_ASSERT_NOW(a_page2_map, out_valid_o,
    page_2_o == 3'd2 || page_2_o == 3'd6, "bad page at 8000-BFFF")

  // A stalled result holds
  `VGPB_ASSERT_NEXT(a_stall_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(pixels_o) && $stable(pixel_count_o) &&
    $stable(upper_rom_number_o), "stalled result changed")

endmodule

bind video_gate_array_palette_and_banking vgpb_checker u_vgpb_checker (.*);
